/* rtl/bmhpq_pkg.sv */
`default_nettype none

package bmhpq_pkg;

  localparam int CAP_W     = 9;
  localparam int IN_KEY_W  = 32;
  localparam int OUT_KEY_W = 32;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 9;
  localparam int OUT_DATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count;
    status_t              status;
    logic [OUT_KEY_W-1:0] min_key;
  } res_t;

endpackage

`default_nettype wire

/* rtl/bmhpq_mem.sv */
`default_nettype none

module bmhpq_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         ra_data,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

/* rtl/bmhpq_ctrl.sv */
`default_nettype none

module bmhpq_ctrl #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [bmhpq_pkg::CAP_W-1:0]   cap,
  input  wire logic                          in_valid,
  input  wire logic                          in_kind,
  input  wire logic [bmhpq_pkg::IN_KEY_W-1:0] in_key,
  output logic                               in_ready,
  input  wire logic                          res_ready,
  output logic                               res_valid,
  output bmhpq_pkg::res_t                    res,
  output logic                               mem_we,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr,
  output logic [KEY_WIDTH-1:0]               mem_wdata,
  output logic [$clog2(DEPTH)-1:0]           mem_ra_addr,
  output logic [$clog2(DEPTH)-1:0]           mem_rb_addr,
  input  wire logic [KEY_WIDTH-1:0]          mem_ra_data,
  input  wire logic [KEY_WIDTH-1:0]          mem_rb_data
);

  import bmhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CW > CAP_W) ? CW : CAP_W;
  localparam int XW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_RM_LD,
    S_SD_RD,
    S_SD_CMP,
    S_FIN
  } state_t;

  state_t          state_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   pos_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] top_r;
  status_t         status_r;

  logic            full;
  logic [AW-1:0]   up_idx;
  logic [XW-1:0]   ch_idx;
  logic [XW-1:0]   ch_idx_b;
  logic            ch_none;
  logic            pick_b;
  logic [KEY_WIDTH-1:0] ch_key;
  logic [XW-1:0]   ch_sel;

  assign full     = (cnt_r >= CW'(DEPTH)) || (WW'(cnt_r) >= WW'(cap));
  assign up_idx   = (pos_r - AW'(1)) >> 1;
  assign ch_idx   = (XW'(pos_r) << 1) + XW'(1);
  assign ch_idx_b = ch_idx + XW'(1);
  assign ch_none  = ch_idx >= XW'(cnt_r);
  // take the right child only when it exists and is strictly smaller
  assign pick_b   = (ch_idx_b < XW'(cnt_r)) && (mem_rb_data < mem_ra_data);
  assign ch_key   = pick_b ? mem_rb_data : mem_ra_data;
  assign ch_sel   = pick_b ? ch_idx_b : ch_idx;

  assign in_ready      = (state_r == S_IDLE);
  assign res_valid     = (state_r == S_FIN);
  assign res.min_key   = OUT_KEY_W'(top_r);
  assign res.status    = status_r;
  assign res.count     = CNT_OUT_W'(cnt_r);

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = pos_r;
    mem_wdata   = key_r;
    mem_ra_addr = up_idx;
    mem_rb_addr = cnt_r[AW-1:0];
    unique case (state_r)
      S_UP_RD: begin
        mem_we = (pos_r == '0);
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (mem_ra_data > key_r) begin
          mem_wdata = mem_ra_data;
        end
      end
      S_RM_RD: begin
        mem_ra_addr = '0;
      end
      S_SD_RD: begin
        mem_we      = ch_none;
        mem_ra_addr = ch_idx[AW-1:0];
        mem_rb_addr = ch_idx_b[AW-1:0];
      end
      S_SD_CMP: begin
        mem_we = 1'b1;
        if (key_r > ch_key) begin
          mem_wdata = ch_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      status_r <= STAT_DONE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            top_r    <= '0;
            status_r <= STAT_DONE;
            if (in_kind == KIND_INSERT) begin
              if (full) begin
                status_r <= STAT_FULL;
                state_r  <= S_FIN;
              end else begin
                key_r   <= KEY_WIDTH'(in_key);
                pos_r   <= cnt_r[AW-1:0];
                cnt_r   <= cnt_r + CW'(1);
                state_r <= S_UP_RD;
              end
            end else begin
              if (cnt_r == '0) begin
                status_r <= STAT_EMPTY;
                state_r  <= S_FIN;
              end else begin
                cnt_r   <= cnt_r - CW'(1);
                state_r <= S_RM_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state_r <= (pos_r == '0) ? S_FIN : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (mem_ra_data > key_r) begin
            pos_r   <= up_idx;
            state_r <= S_UP_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_RM_RD: begin
          state_r <= S_RM_LD;
        end
        S_RM_LD: begin
          top_r   <= mem_ra_data;
          key_r   <= mem_rb_data;
          pos_r   <= '0;
          state_r <= (cnt_r == '0) ? S_FIN : S_SD_RD;
        end
        S_SD_RD: begin
          state_r <= ch_none ? S_FIN : S_SD_CMP;
        end
        S_SD_CMP: begin
          if (key_r > ch_key) begin
            pos_r   <= ch_sel[AW-1:0];
            state_r <= S_SD_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/binary_min_heap_priority_queue_unit.sv */
// Binary min-heap priority queue.
// Input stream: in_tuser is the operation (0 insert, 1 remove minimum),
// in_tdata carries the key. Each accepted word yields exactly one result word.
// Result stream: out_tdata holds min_key, status (0 done, 1 full, 2 empty)
// and the count of keys held after the operation.
// cfg_valid/cfg_data write the capacity register (keys allowed, clipped to
// DEPTH); it is always ready and must only be written while the unit is idle.
// Keys live in a single RAM with one write and two read ports (registered reads).
// A rejected word goes straight to its result. An insert compares the key with
// each parent in turn, moving the parent down, until the key settles; a remove
// reads the root and the last key, then sifts the last key down level by level
// until a compare stops it, and skips the sift when it takes the only key.
// Each level reads both children together. in_tready returns as the result
// moves to the output register, so the unit handles one word at a time.
// A finished result sits in the output register; the next word is accepted
// while it waits, and the unit holds its following result until out_tready.
// Reset (rst_n low, synchronous) empties the heap and sets capacity to 256;
// the RAM itself is not cleared.
`default_nettype none

module binary_min_heap_priority_queue_unit #(
  parameter int DEPTH     = 256,
  parameter int KEY_WIDTH = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [bmhpq_pkg::CAP_W-1:0]       cfg_data,    // capacity
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [bmhpq_pkg::IN_KEY_W-1:0]    in_tdata,    // key
  input  wire logic                              in_tuser,    // kind
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // min_key[31:0], status[33:32], count[42:34], zero[47:43]
  output logic [bmhpq_pkg::OUT_DATA_W-1:0]       out_tdata
);

  import bmhpq_pkg::*;

  localparam int AW = $clog2(DEPTH);

  logic [CAP_W-1:0]      cap_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [KEY_WIDTH-1:0]  mem_wdata;
  logic [AW-1:0]         mem_ra_addr;
  logic [AW-1:0]         mem_rb_addr;
  logic [KEY_WIDTH-1:0]  mem_ra_data;
  logic [KEY_WIDTH-1:0]  mem_rb_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  bmhpq_ctrl #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .cap         (cap_r),
    .in_valid    (in_tvalid),
    .in_kind     (in_tuser),
    .in_key      (in_tdata),
    .in_ready    (in_tready),
    .res_ready   (res_ready),
    .res_valid   (res_valid),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_ra_addr (mem_ra_addr),
    .mem_rb_addr (mem_rb_addr),
    .mem_ra_data (mem_ra_data),
    .mem_rb_data (mem_rb_data)
  );

  bmhpq_mem #(
    .DEPTH (DEPTH),
    .WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .ra_addr (mem_ra_addr),
    .rb_addr (mem_rb_addr),
    .ra_data (mem_ra_data),
    .rb_data (mem_rb_data)
  );

  // load a new word when the register is empty or being drained
  assign res_ready = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res_ready) begin
      out_tvalid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_tdata_r <= OUT_DATA_W'(res);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

/* rtl/bmhpq_chk.sv */
`default_nettype none

module bmhpq_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);

  import bmhpq_pkg::*;

  logic [1:0] stat;
  logic [8:0] cnt;
  logic [31:0] mkey;

  assign mkey = out_tdata[31:0];
  assign stat = out_tdata[33:32];
  assign cnt  = out_tdata[42:34];

  // stalled word must stay valid
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped under stall");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat == STAT_EMPTY |-> cnt == 9'd0 && mkey == 32'd0)
    else $error("empty status with keys or a nonzero minimum");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && stat == STAT_FULL |-> mkey == 32'd0)
    else $error("rejected insert returned a key");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> stat == STAT_DONE || stat == STAT_FULL || stat == STAT_EMPTY)
    else $error("undefined status code");

endmodule

bind binary_min_heap_priority_queue_unit bmhpq_chk u_bmhpq_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* tb/binary_min_heap_priority_queue_unit_tb.sv */
`timescale 1ns / 100ps

module binary_min_heap_priority_queue_unit_tb;
  import bmhpq_pkg::*;

  localparam int DEPTH      = 256;
  localparam int KEY_WIDTH  = 32;
  localparam int STALL_MAX  = 2000;
  localparam int IDLE_PAUSE = 30;

  typedef struct {
    kind_t               kind;
    logic [IN_KEY_W-1:0] key;
  } heap_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CAP_W-1:0]      cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_KEY_W-1:0]   in_tdata = '0;    // key
  logic                  in_tuser = 1'b0;  // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // min_key[31:0], status[33:32], count[42:34], zero[47:43]
  logic [OUT_DATA_W-1:0] out_tdata;

  // predictor state
  logic [KEY_WIDTH-1:0] heap_keys [DEPTH];
  int                   heap_n = 0;
  logic [CAP_W-1:0]     heap_cap = CAP_RESET;

  heap_op_t heap_ops_q [$];
  res_t     heap_results_q [$];

  int  n_sent = 0;
  int  n_results = 0;
  int  n_errors = 0;
  int  n_inserts = 0;
  int  n_removes = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  n_cfg = 0;
  int  peak_count = 0;
  int  stall_cycles = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_bursty = 1'b0;
  bit  out_bursty = 1'b0;
  bit  in_fire = 1'b0;

  binary_min_heap_priority_queue_unit #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One heap operation, applied to the predictor's own copy of the heap.
  task automatic heap_apply(input kind_t op, input logic [KEY_WIDTH-1:0] key,
                            output res_t r);
    int                   limit;
    int                   pos;
    int                   up;
    int                   ch;
    int                   n;
    logic [KEY_WIDTH-1:0] last;
    r = '0;
    r.status = STAT_DONE;
    limit = (heap_cap > DEPTH) ? DEPTH : int'(heap_cap);
    if (op == KIND_INSERT) begin
      n_inserts++;
      if (heap_n >= limit) begin
        r.status = STAT_FULL;
        n_full++;
      end else begin
        pos = heap_n;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (heap_keys[up] > key) begin
            heap_keys[pos] = heap_keys[up];
            pos = up;
          end else begin
            break;
          end
        end
        heap_keys[pos] = key;
        heap_n++;
      end
    end else begin
      n_removes++;
      if (heap_n == 0) begin
        r.status = STAT_EMPTY;
        n_empty++;
      end else begin
        r.min_key = heap_keys[0];
        heap_n--;
        n = heap_n;
        last = heap_keys[n];
        pos = 0;
        while (1) begin
          ch = 2 * pos + 1;
          if (ch >= n) break;
          // right child wins only when strictly smaller
          if (ch + 1 < n && heap_keys[ch + 1] < heap_keys[ch]) ch++;
          if (last > heap_keys[ch]) begin
            heap_keys[pos] = heap_keys[ch];
            pos = ch;
          end else begin
            break;
          end
        end
        if (n > 0) heap_keys[pos] = last;
      end
    end
    r.count = heap_n[CNT_OUT_W-1:0];
    if (heap_n > peak_count) peak_count = heap_n;
  endtask

  // Input driver: present the next word, hold until taken, idle in bursts.
  always @(negedge clk) begin
    heap_op_t op;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap--;
      end else if (heap_ops_q.size() > 0) begin
        op = heap_ops_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= op.kind;
        in_tdata <= op.key;
        if (in_bursty && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 13);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap--;
    end else begin
      out_tready <= 1'b1;
      if (out_bursty && $urandom_range(0, 6) == 0) out_gap = $urandom_range(1, 13);
    end
  end

  // Monitor: track config, predict on accepted words, check results.
  always @(posedge clk) begin
    res_t want;
    res_t got;
    bit   moved;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        heap_cap = cfg_data;
        n_cfg++;
        moved = 1'b1;
      end
      if (in_tvalid && in_tready) begin
        heap_apply(kind_t'(in_tuser), in_tdata, want);
        heap_results_q.push_back(want);
        moved = 1'b1;
      end
      in_fire <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        n_results++;
        got = out_tdata[CNT_OUT_W+STAT_W+OUT_KEY_W-1:0];
        if (heap_results_q.size() == 0) begin
          $error("result word with nothing expected: %h", out_tdata);
          n_errors++;
        end else begin
          want = heap_results_q.pop_front();
          if (got.min_key !== want.min_key) begin
            $error("min_key: expected %h, got %h", want.min_key, got.min_key);
            n_errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            n_errors++;
          end
          if (got.count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, got.count);
            n_errors++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_MAX) begin
        $display("watchdog: no handshake for %0d cycles", STALL_MAX);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic queue_op(input kind_t kind, input logic [IN_KEY_W-1:0] key);
    heap_op_t op;
    op.kind = kind;
    op.key = key;
    heap_ops_q.push_back(op);
    n_sent++;
  endtask

  task automatic wait_drained();
    while (n_results != n_sent) @(negedge clk);
  endtask

  // Write capacity only once the heap has gone quiet.
  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (IDLE_PAUSE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [IN_KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 15);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(input logic [CAP_W-1:0] cap, input int n_ops,
                              input int ins_pct, input bit in_idle, input bit out_idle);
    set_capacity(cap);
    in_bursty = in_idle;
    out_bursty = out_idle;
    repeat (n_ops)
      queue_op(($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_REMOVE, pick_key());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty remove, extreme keys, ties, drain past empty
    in_bursty = 1'b1;
    out_bursty = 1'b1;
    queue_op(KIND_REMOVE, 32'hFFFF_FFFF);
    queue_op(KIND_INSERT, 32'h0000_0000);
    queue_op(KIND_INSERT, 32'hFFFF_FFFF);
    queue_op(KIND_INSERT, 32'h8000_0000);
    queue_op(KIND_INSERT, 32'h0000_0007);
    queue_op(KIND_INSERT, 32'h0000_0007);
    queue_op(KIND_INSERT, 32'h0000_0001);
    repeat (7) queue_op(KIND_REMOVE, $urandom());

    // zero capacity: always full
    set_capacity(9'd0);
    queue_op(KIND_INSERT, 32'h1234_5678);
    queue_op(KIND_REMOVE, 32'h0);

    // capacity two: third insert is rejected
    set_capacity(9'd2);
    queue_op(KIND_INSERT, 32'h0000_0009);
    queue_op(KIND_INSERT, 32'h0000_0003);
    queue_op(KIND_INSERT, 32'h0000_0005);

    // capacity lowered below the count held
    set_capacity(9'd1);
    queue_op(KIND_INSERT, 32'h0000_0002);
    queue_op(KIND_REMOVE, 32'h0);
    queue_op(KIND_INSERT, 32'h0000_0004);
    queue_op(KIND_REMOVE, 32'h0);
    queue_op(KIND_INSERT, 32'hDEAD_BEEF);

    // fill to the top and drain back out
    random_phase(9'd256, 280, 95, 1'b1, 1'b1);
    random_phase(9'd256, 250, 8, 1'b1, 1'b0);
    random_phase(9'd7, 150, 55, 1'b0, 1'b1);
    random_phase(9'd511, 150, 60, 1'b1, 1'b1);
    random_phase(9'd1, 60, 50, 1'b1, 1'b1);
    random_phase(9'd300, 100, 85, 1'b1, 1'b0);
    random_phase(9'd20, 100, 50, 1'b1, 1'b1);
    random_phase(9'd256, 150, 50, 1'b0, 1'b0);

    wait_drained();
    repeat (40) @(posedge clk);
    if (heap_results_q.size() != 0) begin
      $error("%0d expected results never arrived", heap_results_q.size());
      n_errors++;
    end
    $display("%0d words (%0d inserts, %0d removes), %0d capacity writes, peak count %0d",
             n_sent, n_inserts, n_removes, n_cfg, peak_count);
    $display("rejected: %0d on full heap, %0d on empty heap; %0d errors",
             n_full, n_empty, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
